// ===== sv/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the sorted sleep queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int TIME_W          = 64;
    localparam int ID_W            = 8;

    localparam logic [1:0] KIND_INSERTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_WOKEN    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic                     func;
        logic [ID_W-1:0]          thread_id;
        logic signed [TIME_W-1:0] time_value;
    } ssq_in_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] woken_id;
        logic            last;
    } ssq_out_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] wake_time;
        logic [ID_W-1:0]          sleeper_id;
    } ssq_entry_t;

    localparam int ENTRY_W = $bits(ssq_entry_t);

endpackage

`default_nettype wire

// ===== sv/sorted_sleep_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_sleep_queue
// Bounded queue of sleeping thread ids kept sorted by wake time.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_data) takes one item at a
// time. A sleep item (func 0) inserts an id after every entry whose wake time
// is earlier or equal; a tick item (func 1) wakes due entries from the head.
// The output channel (out_valid, out_ready, out_data) gives one item per
// woken id, or one item for an insert, a rejected insert, or a tick that
// wakes nothing; last marks the final item of each input item.
// Entries live in a circular RAM with a head pointer. A sleep item reads the
// entries from the tail, moves each later entry back one place, and writes
// the new entry into the gap; a full queue rejects it without a RAM access.
// A tick item reads entries from the head until one is not yet due, the
// queue ends or MAX_RESULTS are woken, then moves the head past the woken
// entries. Each entry is read through the single RAM read port, whose data
// is registered. in_ready rises with the final item, so the next item can
// be accepted while the final item is valid. After reset the queue is empty.
// A stalled receiver holds the output register and delays the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sleep_queue #(
    parameter int QUEUE_DEPTH = ssq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ssq_pkg::ssq_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ssq_pkg::ssq_out_t      out_data
);

    import ssq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RESP,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   idx_reg, idx_next;
    ssq_in_t         item_reg, item_next;
    logic [1:0]      kind_reg, kind_next;
    logic [ID_W-1:0] pend_id_reg, pend_id_next;
    logic            out_valid_reg, out_valid_next;
    ssq_out_t        out_data_reg, out_data_next;

    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    ssq_entry_t      ram_wdata;
    ssq_entry_t      ram_rdata;
    logic [CW-1:0]   ridx;
    logic [CW:0]     wsum;
    logic [CW:0]     rsum;
    logic            can_emit;
    logic [TIME_W-1:0] diff;
    logic            due;
    logic            more;

    ssq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ridx = (state_reg == S_INS_RD) ? (idx_reg - CW'(1)) : idx_reg;
        wsum = (CW+1)'(head_reg) + (CW+1)'(idx_reg);
        if (wsum >= (CW+1)'(QUEUE_DEPTH))
        begin
            wsum = wsum - (CW+1)'(QUEUE_DEPTH);
        end
        rsum = (CW+1)'(head_reg) + (CW+1)'(ridx);
        if (rsum >= (CW+1)'(QUEUE_DEPTH))
        begin
            rsum = rsum - (CW+1)'(QUEUE_DEPTH);
        end
        waddr = AW'(wsum);
        raddr = AW'(rsum);
    end

    assign can_emit = !out_valid_reg || out_ready;
    assign diff     = item_reg.time_value - ram_rdata.wake_time;
    assign due      = !diff[TIME_W-1];
    assign more     = (idx_reg < occ_reg) && (int'(idx_reg) < MAX_RESULTS);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        kind_next      = kind_reg;
        pend_id_next   = pend_id_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = '{wake_time: item_reg.time_value, sleeper_id: item_reg.thread_id};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    idx_next  = in_data.func ? '0 : occ_reg;
                    if (in_data.func)
                    begin
                        state_next = S_TICK_RD;
                    end
                    else if (occ_reg == CW'(QUEUE_DEPTH))
                    begin
                        kind_next  = KIND_REJECTED;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    occ_next   = occ_reg + CW'(1);
                    kind_next  = KIND_INSERTED;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (item_reg.time_value < ram_rdata.wake_time)
                begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    occ_next   = occ_reg + CW'(1);
                    kind_next  = KIND_INSERTED;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{kind: kind_reg, woken_id: '0, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                if (more)
                begin
                    ram_re     = 1'b1;
                    state_next = S_TICK_CMP;
                end
                else
                begin
                    state_next = S_TICK_FIN;
                end
            end
            S_TICK_CMP:
            begin
                if (!due)
                begin
                    state_next = S_TICK_FIN;
                end
                else if (idx_reg == '0 || can_emit)
                begin
                    if (idx_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{kind: KIND_WOKEN, woken_id: pend_id_reg,
                                           last: 1'b0};
                    end
                    pend_id_next = ram_rdata.sleeper_id;
                    idx_next     = idx_reg + CW'(1);
                    state_next   = S_TICK_RD;
                end
            end
            S_TICK_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (idx_reg != '0)
                    begin
                        out_data_next = '{kind: KIND_WOKEN, woken_id: pend_id_reg,
                                          last: 1'b1};
                    end
                    else
                    begin
                        out_data_next = '{kind: KIND_NONE, woken_id: '0, last: 1'b1};
                    end
                    head_next  = waddr;
                    occ_next   = occ_reg - idx_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            item_reg      <= '0;
            kind_reg      <= KIND_INSERTED;
            pend_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            item_reg      <= item_next;
            kind_reg      <= kind_next;
            pend_id_reg   <= pend_id_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.func && occ_reg == CW'(QUEUE_DEPTH))
        |=> (occ_reg == $past(occ_reg) && state_reg == S_RESP))
        else $error("insert into a full queue was not rejected");

    a_not_last_is_woken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.last) |-> (out_data.kind == KIND_WOKEN))
        else $error("non-final item is not a woken thread");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (idx_reg <= occ_reg))
        else $error("entry index beyond occupancy");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (occ_reg < CW'(QUEUE_DEPTH)))
        else $error("RAM written while the queue is full");
`endif

endmodule

`default_nettype wire

// ===== sv/ssq_ram.sv =====
// ----------------------------------------------------------------------------
// ssq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
